[rtl/epoch_tagged_address_change_table_assert.svh]
// assertion macros used by the table rtl
`ifndef EPOCH_TAGGED_ADDRESS_CHANGE_TABLE_ASSERT_SVH
`define EPOCH_TAGGED_ADDRESS_CHANGE_TABLE_ASSERT_SVH

// same-cycle implication
`define ETACT_ASSERT_NOW(label, cond, conseq) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (conseq)) \
    else $error("%m: same-cycle check failed");

// next-cycle implication
`define ETACT_ASSERT_NEXT(label, cond, conseq) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (conseq)) \
    else $error("%m: next-cycle check failed");

`endif

[rtl/etact_pkg.sv]
package etact_pkg;

  localparam int SECTIONS      = 1024;
  localparam int SECTION_TYPES = 64;

  localparam int ID_W    = 10;
  localparam int TYPE_W  = 6;
  localparam int ADDR_W  = 64;
  localparam int EPOCH_W = 32;
  localparam int CNT_W   = 16;
  localparam int LIMIT_W = 11;
  localparam int QUOTA_W = 7;
  localparam int GEN_W   = 8;
  localparam int CFG_W   = 11;

  localparam int IN_DATA_W  = 88;
  localparam int OUT_DATA_W = 104;

  // generation tag zero marks a cleared entry and is never the live tag
  localparam logic [GEN_W-1:0] GEN_FIRST = GEN_W'(1);
  localparam logic [GEN_W-1:0] GEN_LAST  = {GEN_W{1'b1}};

  localparam logic [SECTION_TYPES-1:0] TYPE_MASK_BITS = {SECTION_TYPES{1'b1}};
  localparam logic [63:0] TYPE_MASK = 64'(TYPE_MASK_BITS);

  typedef enum logic [2:0] {
    FUNC_SET_ADDR  = 3'd0,
    FUNC_ZERO_SIZE = 3'd1,
    FUNC_MARK_TYPE = 3'd2,
    FUNC_COMPLETE  = 3'd3,
    FUNC_ABORT     = 3'd4
  } func_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_CONFLICT = 2'd1,
    ST_BAD_ID   = 2'd2,
    ST_BAD_TYPE = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    CFG_SECTION_LIMIT     = 2'd0,
    CFG_SECTIONS_EXPECTED = 2'd1,
    CFG_ENFORCE_SCRATCH   = 2'd2,
    CFG_FORCED_QUOTA      = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic [GEN_W-1:0]   gen;
    logic [EPOCH_W-1:0] epoch;
    logic [ADDR_W-1:0]  addr;
  } entry_t;

  typedef struct packed {
    logic            en;
    logic [ID_W-1:0] idx;
    entry_t          entry;
  } ram_wr_t;

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    return (v == {CNT_W{1'b1}}) ? v : v + CNT_W'(1);
  endfunction

endpackage

[rtl/etact_ram.sv]
module etact_ram (
  input  logic                   clk,
  input  logic                   rd_en,
  input  logic [etact_pkg::ID_W-1:0] rd_idx,
  output etact_pkg::entry_t      rd_entry,
  input  etact_pkg::ram_wr_t     wr
);
  import etact_pkg::*;

  entry_t mem [SECTIONS];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.idx] <= wr.entry;
    end
  end

  // read sees the old word when the same entry is written on this edge
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_entry <= mem[rd_idx];
    end
  end

endmodule

[rtl/epoch_tagged_address_change_table.sv]
// channel   dir  tdata (low bit up)                                    tuser
// s_axis    in   section_id, section_type, host_address, zero_size,    func
//                force_update, scratchpad (88 bits)
// m_axis    out  status, has_new_address, all_checked, types_pending,  -
//                updated_count, checked_count (104 bits)
// cfg       in   cfg_we, cfg_index, cfg_data                           -
//
// one word per cycle when no stall holds it: the table ram is read on the
// accept edge, the entry is updated from the item stage and the result lands
// in the output register. a one-word bypass covers a back-to-back hit on the
// entry just written. after rst, and after every 255th abort, a clearing pass
// writes all 1024 entries, one per cycle, while s_axis_tready stays low.
// m_axis_tready low holds the result and the stage behind it.
`include "epoch_tagged_address_change_table_assert.svh"

module epoch_tagged_address_change_table (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  s_axis_tvalid,
  output logic                                  s_axis_tready,
  // section_id, section_type, host_address, zero_size, force_update, scratchpad
  input  logic [etact_pkg::IN_DATA_W-1:0]       s_axis_tdata,
  // func
  input  logic [2:0]                            s_axis_tuser,
  output logic                                  m_axis_tvalid,
  input  logic                                  m_axis_tready,
  // status, has_new_address, all_checked, types_pending, updated_count,
  // checked_count
  output logic [etact_pkg::OUT_DATA_W-1:0]      m_axis_tdata,
  input  logic                                  cfg_we,
  input  logic [1:0]                            cfg_index,
  input  logic [etact_pkg::CFG_W-1:0]           cfg_data
);
  import etact_pkg::*;

  // configuration
  logic [LIMIT_W-1:0] section_limit;
  logic [LIMIT_W-1:0] sections_expected;
  logic               enforce_scratch;
  logic [QUOTA_W-1:0] forced_quota;

  // epoch state
  logic [EPOCH_W-1:0] cur_epoch, cur_epoch_next;
  logic [CNT_W-1:0]   updated_total, updated_total_next;
  logic [CNT_W-1:0]   checked_total, checked_total_next;
  logic [QUOTA_W-1:0] forced_groups, forced_groups_next;
  logic [63:0]        pending_types, pending_types_next;
  logic [GEN_W-1:0]   gen, gen_next;

  // clearing pass
  logic               clearing;
  logic [ID_W-1:0]    clr_idx;
  logic               start_clear;

  // item stage
  logic               s1_valid;
  func_t              s1_func;
  logic [ID_W-1:0]    s1_id;
  logic [TYPE_W-1:0]  s1_type;
  logic [ADDR_W-1:0]  s1_host;
  logic               s1_zsize;
  logic               s1_force;
  logic               s1_scratch;

  // bypass of the last write
  logic               fwd_valid;
  logic [ID_W-1:0]    fwd_idx;
  entry_t             fwd_entry;

  // result register
  logic                  res_valid;
  logic [OUT_DATA_W-1:0] res_data, res_data_next;

  logic    s_acc, m_acc, adv, proc, wrap_hold;
  entry_t  ram_rd, cur_ent;
  ram_wr_t ram_wr, upd_wr;

  logic               ent_live, id_ok, type_ok, change, forced, confirm;
  logic [ADDR_W-1:0]  cur_addr, new_addr;
  logic [EPOCH_W-1:0] cur_ep, new_ep;
  logic [63:0]        tbit;
  status_t            status;

  assign adv       = !res_valid || m_axis_tready;
  assign proc      = s1_valid && adv;
  assign wrap_hold = s1_valid && (s1_func == FUNC_ABORT) && (gen == GEN_LAST);
  assign s_axis_tready = !clearing && !wrap_hold && (!s1_valid || adv);
  assign s_acc     = s_axis_tvalid && s_axis_tready;
  assign m_acc     = m_axis_tvalid && m_axis_tready;
  assign m_axis_tvalid = res_valid;
  assign m_axis_tdata  = res_data;

  etact_ram u_ram (
    .clk      (clk),
    .rd_en    (s_acc),
    .rd_idx   (s_axis_tdata[ID_W-1:0]),
    .rd_entry (ram_rd),
    .wr       (ram_wr)
  );

  always_comb begin
    ram_wr = upd_wr;
    ram_wr.en = proc && upd_wr.en;
    if (clearing) begin
      ram_wr.en    = 1'b1;
      ram_wr.idx   = clr_idx;
      ram_wr.entry = '0;
    end
  end

  // entry as seen by the item in the stage
  assign cur_ent  = (fwd_valid && (fwd_idx == s1_id)) ? fwd_entry : ram_rd;
  assign ent_live = (cur_ent.gen == gen);
  assign cur_addr = ent_live ? cur_ent.addr : '0;
  assign cur_ep   = ent_live ? cur_ent.epoch : '0;
  assign id_ok    = (LIMIT_W'(s1_id) < section_limit) && (LIMIT_W'(s1_id) < LIMIT_W'(SECTIONS));
  assign type_ok  = (7'(s1_type) < 7'(SECTION_TYPES));
  assign tbit     = 64'(1) << s1_type;

  always_comb begin
    status              = ST_OK;
    cur_epoch_next      = cur_epoch;
    updated_total_next  = updated_total;
    checked_total_next  = checked_total;
    forced_groups_next  = forced_groups;
    pending_types_next  = pending_types;
    gen_next            = gen;
    start_clear         = 1'b0;
    change              = 1'b0;
    forced              = 1'b0;
    confirm             = 1'b0;
    new_addr            = cur_addr;
    new_ep              = cur_ep;
    upd_wr.en           = 1'b0;
    upd_wr.idx          = s1_id;
    upd_wr.entry        = '{gen: gen, epoch: cur_ep, addr: cur_addr};

    unique case (s1_func)
      FUNC_SET_ADDR: begin
        if (!id_ok) begin
          status = ST_BAD_ID;
        end else if (!type_ok) begin
          status = ST_BAD_TYPE;
        end else if (cur_ep == cur_epoch) begin
          // already confirmed this epoch
          if ((cur_addr == s1_host) || (s1_host == '0)) begin
            status = ST_OK;
          end else if (cur_addr == '0) begin
            upd_wr.en          = 1'b1;
            upd_wr.entry.addr  = s1_host;
            checked_total_next = sat_inc(checked_total);
          end else begin
            status = ST_CONFLICT;
          end
        end else begin
          change = (cur_addr != s1_host) || s1_force;
          if (s1_scratch) begin
            if (enforce_scratch) begin
              change = 1'b1;
            end
          end else if (forced_groups < forced_quota) begin
            change = 1'b1;
            forced = 1'b1;
          end
          if (change) begin
            updated_total_next = sat_inc(updated_total);
            if (forced && ((pending_types & tbit) == '0)) begin
              forced_groups_next = forced_groups + QUOTA_W'(1);
            end
            pending_types_next = pending_types | tbit;
            new_addr = s1_host;
          end
          confirm = (s1_host != '0) || s1_zsize;
          if (confirm) begin
            new_ep = cur_epoch;
            checked_total_next = sat_inc(checked_total);
          end
          upd_wr.en    = change || confirm;
          upd_wr.entry = '{gen: gen, epoch: new_ep, addr: new_addr};
        end
      end
      FUNC_ZERO_SIZE: begin
        if (!id_ok) begin
          status = ST_BAD_ID;
        end else if (cur_ep != cur_epoch) begin
          upd_wr.en          = 1'b1;
          upd_wr.entry.epoch = cur_epoch;
          checked_total_next = sat_inc(checked_total);
        end
      end
      FUNC_MARK_TYPE: begin
        if (!type_ok) begin
          status = ST_BAD_TYPE;
        end else begin
          pending_types_next = pending_types | tbit;
        end
      end
      FUNC_COMPLETE: begin
        cur_epoch_next     = cur_epoch + EPOCH_W'(1);
        updated_total_next = '0;
        checked_total_next = '0;
        forced_groups_next = '0;
        pending_types_next = '0;
      end
      FUNC_ABORT: begin
        cur_epoch_next     = EPOCH_W'(1);
        updated_total_next = '0;
        checked_total_next = '0;
        forced_groups_next = '0;
        pending_types_next = '0;
        // new tag retires every entry; a tag wrap needs a real sweep
        if (gen == GEN_LAST) begin
          gen_next    = GEN_FIRST;
          start_clear = 1'b1;
        end else begin
          gen_next = gen + GEN_W'(1);
        end
      end
      default: begin
        status = ST_OK;
      end
    endcase

    res_data_next = OUT_DATA_W'({
      checked_total_next,
      updated_total_next,
      pending_types_next & TYPE_MASK,
      (checked_total_next == CNT_W'(sections_expected)),
      (updated_total_next != '0),
      status
    });
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      section_limit     <= LIMIT_W'(SECTIONS);
      sections_expected <= '0;
      enforce_scratch   <= 1'b0;
      forced_quota      <= '0;
      cur_epoch         <= EPOCH_W'(1);
      updated_total     <= '0;
      checked_total     <= '0;
      forced_groups     <= '0;
      pending_types     <= '0;
      gen               <= GEN_FIRST;
      clearing          <= 1'b1;
      clr_idx           <= '0;
      s1_valid          <= 1'b0;
      fwd_valid         <= 1'b0;
      res_valid         <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_idx_t'(cfg_index))
          CFG_SECTION_LIMIT:     section_limit     <= cfg_data[LIMIT_W-1:0];
          CFG_SECTIONS_EXPECTED: sections_expected <= cfg_data[LIMIT_W-1:0];
          CFG_ENFORCE_SCRATCH:   enforce_scratch   <= cfg_data[0];
          CFG_FORCED_QUOTA:      forced_quota      <= cfg_data[QUOTA_W-1:0];
          default:               enforce_scratch   <= enforce_scratch;
        endcase
      end

      if (clearing) begin
        fwd_valid <= 1'b0;
        clr_idx   <= clr_idx + ID_W'(1);
        if (clr_idx == ID_W'(SECTIONS - 1)) begin
          clearing <= 1'b0;
        end
      end

      if (s_acc) begin
        s1_valid <= 1'b1;
      end else if (proc) begin
        s1_valid <= 1'b0;
      end

      if (proc) begin
        cur_epoch     <= cur_epoch_next;
        updated_total <= updated_total_next;
        checked_total <= checked_total_next;
        forced_groups <= forced_groups_next;
        pending_types <= pending_types_next;
        gen           <= gen_next;
        res_valid     <= 1'b1;
        if (start_clear) begin
          clearing  <= 1'b1;
          clr_idx   <= '0;
          fwd_valid <= 1'b0;
        end else if (upd_wr.en) begin
          fwd_valid <= 1'b1;
        end
      end else if (m_acc) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_acc) begin
      s1_func    <= func_t'(s_axis_tuser);
      s1_id      <= s_axis_tdata[ID_W-1:0];
      s1_type    <= s_axis_tdata[ID_W +: TYPE_W];
      s1_host    <= s_axis_tdata[ID_W+TYPE_W +: ADDR_W];
      s1_zsize   <= s_axis_tdata[ID_W+TYPE_W+ADDR_W];
      s1_force   <= s_axis_tdata[ID_W+TYPE_W+ADDR_W+1];
      s1_scratch <= s_axis_tdata[ID_W+TYPE_W+ADDR_W+2];
    end
    if (proc) begin
      res_data <= res_data_next;
      if (upd_wr.en) begin
        fwd_idx   <= upd_wr.idx;
        fwd_entry <= upd_wr.entry;
      end
    end
  end

  `ETACT_ASSERT_NOW(a_no_accept_while_clearing, clearing, !s_axis_tready)
  `ETACT_ASSERT_NOW(a_live_tag_nonzero, 1'b1, gen != '0)
  `ETACT_ASSERT_NEXT(a_item_gives_result, proc, res_valid)
  `ETACT_ASSERT_NEXT(a_abort_resets_epoch, proc && (s1_func == FUNC_ABORT), (cur_epoch == EPOCH_W'(1)) && (updated_total == '0))

endmodule
